FILE: design/device_address_allowlist_macros.svh
// Assertion macros used by the allowlist RTL.
`ifndef DEVICE_ADDRESS_ALLOWLIST_MACROS_SVH
`define DEVICE_ADDRESS_ALLOWLIST_MACROS_SVH

// Same-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define DAL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define DAL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dal_pkg.sv
// Types and constants of the device address allowlist.
`default_nettype none

package dal_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_O_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RD,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: design/dal_ram.sv
// Single-clock table memory: one write port, one registered read port.
`default_nettype none

module dal_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 48,
  parameter int unsigned AW    = 3
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/device_address_allowlist.sv
// Top level of the device address allowlist: sequencer, entry count and result register.
// Sequencing: an add writes the address into the append slot unless the table is full; an
//   unused op code goes straight to the result; lookup and remove read and compare entries
//   one at a time through the single read port, and a remove hit shifts later entries down.
// One transaction at a time: a request is taken only in idle, once the last result is parked.
// Reset clears the entry count, sequencer and result valid; the table memory is not cleared.
`default_nettype none
`include "device_address_allowlist_macros.svh"

module device_address_allowlist #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dal_pkg::OP_W-1:0]      op_i,
  input  wire logic [dal_pkg::ADDR_W-1:0]    device_address_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [dal_pkg::STATUS_W-1:0]       status_o,
  output logic                               match_found_o,
  output logic [dal_pkg::COUNT_O_W-1:0]      entry_count_o
);

  import dal_pkg::*;

  // Count runs 0..MAX_ENTRIES; slot index covers 0..MAX_ENTRIES-1.
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     idx_nxt;
  status_e           status_q, status_d;
  logic              match_q, match_d;

  // Result register, parted from the sequencer so a new transaction may start.
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic                 res_match_q, res_match_d;
  logic [COUNT_O_W-1:0] res_count_q, res_count_d;
  logic                 res_load;

  // Table memory controls.
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [ADDR_W-1:0] mem_wdata, mem_rdata;

  logic              in_accept;
  logic              out_take;
  logic              table_full;
  logic              hit;
  logic [CW+COUNT_O_W-1:0] count_ext;

  assign idx_nxt    = idx_q + CW'(1);
  assign table_full = (count_q >= CW'(MAX_ENTRIES));
  assign hit        = (mem_rdata == addr_q);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  // Report the count masked to the result field width.
  assign count_ext  = {{COUNT_O_W{1'b0}}, count_q};

  dal_ram #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(ADDR_W),
    .AW   (IW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_ADD:                 state_d = S_ADD;
            OP_LOOKUP, OP_REMOVE:   state_d = S_RD;
            default:                state_d = S_DONE;
          endcase
        end
      end
      S_ADD: state_d = S_DONE;
      // Walk the packed entries one read at a time until a match or the end.
      S_RD: begin
        state_d = (idx_q < count_q) ? S_CMP : S_DONE;
      end
      S_CMP: begin
        priority if (hit && (op_q == OP_REMOVE)) begin
          state_d = S_SH_RD;
        end else if (hit) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RD;
        end
      end
      // Close the gap: copy entry idx+1 down to idx until the tail.
      S_SH_RD: begin
        state_d = (idx_nxt < count_q) ? S_SH_WR : S_DONE;
      end
      S_SH_WR: state_d = S_SH_RD;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory controls and handshake outputs of the sequencer.
  always_comb begin
    in_stall_o   = 1'b1;
    op_d         = op_q;
    addr_d       = addr_q;
    count_d      = count_q;
    idx_d        = idx_q;
    status_d     = status_q;
    match_d      = match_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_q[IW-1:0];
    mem_raddr    = idx_q[IW-1:0];
    mem_wdata    = mem_rdata;
    res_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d     = op_e'(op_i);
          addr_d   = device_address_i;
          idx_d    = '0;
          status_d = ST_DONE;
          match_d  = 1'b0;
        end
      end
      S_ADD: begin
        if (table_full) begin
          status_d = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = count_q[IW-1:0];
          mem_wdata = addr_q;
          count_d   = count_q + CW'(1);
        end
      end
      S_RD: begin
        if (idx_q < count_q) begin
          mem_re = 1'b1;
        end else if (op_q == OP_REMOVE) begin
          status_d = ST_NOT_FOUND;
        end
      end
      S_CMP: begin
        if (hit) begin
          match_d = 1'b1;
        end else begin
          idx_d = idx_nxt;
        end
      end
      S_SH_RD: begin
        if (idx_nxt < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_nxt[IW-1:0];
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_nxt;
      end
      S_DONE: begin
        res_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  // Result register: load on completion, drop once taken.
  always_comb begin
    out_valid_d  = out_valid_q;
    res_status_d = res_status_q;
    res_match_d  = res_match_q;
    res_count_d  = res_count_q;
    priority if (res_load) begin
      out_valid_d  = 1'b1;
      res_status_d = status_q;
      res_match_d  = match_q;
      res_count_d  = count_ext[COUNT_O_W-1:0];
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    idx_q        <= idx_d;
    status_q     <= status_d;
    match_q      <= match_d;
    res_status_q <= res_status_d;
    res_match_q  <= res_match_d;
    res_count_q  <= res_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign match_found_o = res_match_q;
  assign entry_count_o = res_count_q;

  // Count stays within the table, and moves only on an add or the end of a remove.
  `DAL_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES),
    "entry count beyond table depth")
  `DAL_ASSERT_NXT(a_count_moves, count_d != count_q,
    $past(state_q) == S_ADD || $past(state_q) == S_SH_RD, "entry count changed unexpectedly")
  // Reads and writes of the table touch only live slots (or the append slot).
  `DAL_ASSERT_IMP(a_read_live, mem_re, (state_q == S_RD && idx_q < count_q) ||
    (state_q == S_SH_RD && idx_nxt < count_q), "table read outside live entries")
  `DAL_ASSERT_IMP(a_write_live, mem_we, (state_q == S_ADD && !table_full) ||
    (state_q == S_SH_WR && idx_nxt < count_q), "table write outside live entries")
  // A new transaction is taken only while the sequencer is free.
  `DAL_ASSERT_NXT(a_accept_starts, in_accept,
    state_q != S_IDLE && out_valid_q == $past(out_valid_d), "accept did not start work")

endmodule

`default_nettype wire
